// ===== sv/i2cbbm_pkg.sv =====
// Shared types, constants and phase tables for the bit-banged I2C master.
// Used by every module of the block. It depends on no other file.
`default_nettype none

package i2cbbm_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int UNIT_W      = 16;
    localparam int DELAY_W     = 18;
    localparam int PHASE_W     = 3;
    localparam int BITCNT_W    = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = UNIT_W'(100);

    // Command codes as they arrive on the mode field.
    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_STOP      = 3'd2,
        CMD_WRITE     = 3'd3,
        CMD_READ_ACK  = 3'd4,
        CMD_READ_BYTE = 3'd5,
        CMD_SEND_ACK  = 3'd6
    } cmd_t;

    // How a phase drives the data line.
    typedef enum logic [1:0] {
        SDA_LOW  = 2'd0,
        SDA_HIGH = 2'd1,
        SDA_KEEP = 2'd2,
        SDA_VAR  = 2'd3
    } sda_code_t;

    typedef struct packed {
        logic      scl;
        sda_code_t sda;
        logic [1:0] unit_shift;   // phase length is unit_ticks << unit_shift
        logic      sample;
    } phase_t;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        cmd_t                 cmd;
        logic [BYTE_BITS-1:0] data;
        logic                 ack;
        logic                 sda;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] count;
        logic               has_loop;
        logic [PHASE_W-1:0] loop_first;
        logic [PHASE_W-1:0] loop_last;
    } cmd_info_t;

    function automatic cmd_info_t cmd_info(input cmd_t c);
        cmd_info_t r;
        r = '{count: 3'd0, has_loop: 1'b0, loop_first: 3'd0, loop_last: 3'd0};
        case (c)
            CMD_START:     r.count = 3'd2;
            CMD_STOP:      r.count = 3'd3;
            CMD_WRITE:     r = '{count: 3'd3, has_loop: 1'b1, loop_first: 3'd0, loop_last: 3'd1};
            CMD_READ_ACK:  r.count = 3'd4;
            CMD_READ_BYTE: r = '{count: 3'd5, has_loop: 1'b1, loop_first: 3'd2, loop_last: 3'd4};
            CMD_SEND_ACK:  r.count = 3'd3;
            default:       r.count = 3'd0;
        endcase
        return r;
    endfunction

    function automatic phase_t phase_lookup(input cmd_t c, input logic [PHASE_W-1:0] p);
        phase_t r;
        r = '{scl: 1'b0, sda: SDA_LOW, unit_shift: 2'd0, sample: 1'b0};
        case (c)
            CMD_START: begin
                case (p)
                    3'd0:    r = '{1'b1, SDA_HIGH, 2'd1, 1'b0};
                    3'd1:    r = '{1'b1, SDA_LOW,  2'd1, 1'b0};
                    default: r = '{1'b0, SDA_LOW,  2'd0, 1'b0};
                endcase
            end
            CMD_STOP: begin
                case (p)
                    3'd0:    r = '{1'b0, SDA_LOW,  2'd1, 1'b0};
                    3'd1:    r = '{1'b1, SDA_KEEP, 2'd1, 1'b0};
                    3'd2:    r = '{1'b1, SDA_HIGH, 2'd1, 1'b0};
                    default: r = '{1'b0, SDA_LOW,  2'd0, 1'b0};
                endcase
            end
            CMD_WRITE: begin
                case (p)
                    3'd0:    r = '{1'b0, SDA_KEEP, 2'd1, 1'b0};
                    3'd1:    r = '{1'b1, SDA_VAR,  2'd1, 1'b0};
                    3'd2:    r = '{1'b0, SDA_KEEP, 2'd0, 1'b0};
                    default: r = '{1'b0, SDA_LOW,  2'd0, 1'b0};
                endcase
            end
            CMD_READ_ACK: begin
                case (p)
                    3'd0:    r = '{1'b0, SDA_KEEP, 2'd0, 1'b0};
                    3'd1:    r = '{1'b0, SDA_HIGH, 2'd0, 1'b0};
                    3'd2:    r = '{1'b1, SDA_KEEP, 2'd0, 1'b1};
                    3'd3:    r = '{1'b0, SDA_KEEP, 2'd0, 1'b0};
                    default: r = '{1'b0, SDA_LOW,  2'd0, 1'b0};
                endcase
            end
            CMD_READ_BYTE: begin
                case (p)
                    3'd0:    r = '{1'b0, SDA_KEEP, 2'd0, 1'b0};
                    3'd1:    r = '{1'b0, SDA_HIGH, 2'd0, 1'b0};
                    3'd2:    r = '{1'b1, SDA_KEEP, 2'd0, 1'b1};
                    3'd3:    r = '{1'b1, SDA_KEEP, 2'd0, 1'b0};
                    3'd4:    r = '{1'b0, SDA_KEEP, 2'd2, 1'b0};
                    default: r = '{1'b0, SDA_LOW,  2'd0, 1'b0};
                endcase
            end
            CMD_SEND_ACK: begin
                case (p)
                    3'd0:    r = '{1'b0, SDA_KEEP, 2'd0, 1'b0};
                    3'd1:    r = '{1'b1, SDA_VAR,  2'd1, 1'b0};
                    3'd2:    r = '{1'b0, SDA_KEEP, 2'd0, 1'b0};
                    default: r = '{1'b0, SDA_LOW,  2'd0, 1'b0};
                endcase
            end
            default: r = '{1'b0, SDA_LOW, 2'd0, 1'b0};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/i2cbbm_front.sv =====
// Front end: classifies each incoming tick request into a command record.
// Depends on i2cbbm_pkg.
`default_nettype none

module i2cbbm_front
    import i2cbbm_pkg::*;
(
    input  wire logic [2:0]           mode,
    input  wire logic [BYTE_BITS-1:0] data_in,
    input  wire logic                 ack_in,
    input  wire logic                 sda_in,
    output item_t                     item
);

    always_comb begin
        item.data = data_in;
        item.ack  = ack_in;
        item.sda  = sda_in;
        case (mode)
            CMD_START, CMD_STOP, CMD_WRITE, CMD_READ_ACK, CMD_READ_BYTE, CMD_SEND_ACK:
                item.cmd = cmd_t'(mode);
            default:
                item.cmd = CMD_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/i2cbbm_queue.sv =====
// Short request queue between the front end and the bus sequencer.
// Depends on i2cbbm_pkg.
`default_nettype none

module i2cbbm_queue
    import i2cbbm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       not_full,
    input  wire logic  pop,
    output logic       not_empty,
    output item_t      head_item
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/i2cbbm_back.sv =====
// Back end: the bus phase sequencer plus the result output register.
// Depends on i2cbbm_pkg.
`default_nettype none

module i2cbbm_back
    import i2cbbm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [UNIT_W-1:0]    unit_ticks,
    input  wire logic                 q_valid,
    input  wire item_t                q_item,
    output logic                      q_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_scl_out,
    output logic                      m_sda_out,
    output logic                      m_busy_res,
    output logic                      m_done_res,
    output logic [BYTE_BITS-1:0]      m_read_data,
    output logic                      m_ack_level
);

    cmd_t                 cmd_reg, cmd_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [BITCNT_W-1:0]  bitcnt_reg, bitcnt_next;
    logic [BYTE_BITS-1:0] shift_reg, shift_next;
    logic                 clk_lvl_reg, clk_lvl_next;
    logic                 dat_lvl_reg, dat_lvl_next;
    logic                 ack_seen_reg, ack_seen_next;
    logic                 ack_send_reg, ack_send_next;

    logic                 out_valid_reg;
    logic                 out_scl_reg, out_scl_next;
    logic                 out_sda_reg, out_sda_next;
    logic                 out_busy_reg, out_busy_next;
    logic                 out_done_reg, out_done_next;
    logic [BYTE_BITS-1:0] out_rd_reg, out_rd_next;

    logic [UNIT_W-1:0]    unit;
    phase_t               ph_cur;
    cmd_info_t            info;
    logic [PHASE_W:0]     phase_inc;
    logic [PHASE_W:0]     phase_cand;

    // Loads the line levels and the phase timer for a newly entered phase.
    function automatic void enter_phase(input cmd_t c, input logic [PHASE_W-1:0] p,
                                        input logic [BYTE_BITS-1:0] sh, input logic ats,
                                        input logic [UNIT_W-1:0] u, inout logic clk_l,
                                        inout logic dat_l, output logic [DELAY_W-1:0] dly);
        phase_t ph;
        ph    = phase_lookup(c, p);
        clk_l = ph.scl;
        case (ph.sda)
            SDA_LOW:  dat_l = 1'b0;
            SDA_HIGH: dat_l = 1'b1;
            SDA_VAR:  dat_l = (c == CMD_WRITE) ? sh[BYTE_BITS-1] : ats;
            default:  dat_l = dat_l;
        endcase
        dly = DELAY_W'(u) << ph.unit_shift;
    endfunction

    assign unit  = (unit_ticks == '0) ? UNIT_W'(1) : unit_ticks;
    assign q_pop = q_valid && (!out_valid_reg || m_ready);

    always_comb begin
        cmd_next      = cmd_reg;
        phase_next    = phase_reg;
        delay_next    = delay_reg;
        bitcnt_next   = bitcnt_reg;
        shift_next    = shift_reg;
        clk_lvl_next  = clk_lvl_reg;
        dat_lvl_next  = dat_lvl_reg;
        ack_seen_next = ack_seen_reg;
        ack_send_next = ack_send_reg;
        out_done_next = 1'b0;
        out_rd_next   = '0;
        ph_cur        = '{1'b0, SDA_LOW, 2'd0, 1'b0};
        info          = cmd_info(CMD_NONE);
        phase_inc     = '0;
        phase_cand    = '0;

        // A new command is taken only while nothing is in progress.
        if (cmd_reg == CMD_NONE && q_item.cmd != CMD_NONE) begin
            cmd_next      = q_item.cmd;
            phase_next    = '0;
            bitcnt_next   = '0;
            if (q_item.cmd == CMD_WRITE) begin
                shift_next = q_item.data;
            end else if (q_item.cmd == CMD_READ_BYTE) begin
                shift_next = '0;
            end
            ack_send_next = q_item.ack;
            enter_phase(cmd_next, phase_next, shift_next, ack_send_next, unit,
                        clk_lvl_next, dat_lvl_next, delay_next);
        end

        out_scl_next = clk_lvl_next;
        out_sda_next = dat_lvl_next;

        if (cmd_next != CMD_NONE) begin
            ph_cur = phase_lookup(cmd_next, phase_next);
            info   = cmd_info(cmd_next);
            // Sample SDA on the last tick of a sampling phase, while SCL is high.
            if (ph_cur.sample && delay_next <= DELAY_W'(1)) begin
                if (cmd_next == CMD_READ_ACK) begin
                    ack_seen_next = q_item.sda;
                end else if (cmd_next == CMD_READ_BYTE) begin
                    shift_next = {shift_next[BYTE_BITS-2:0], q_item.sda};
                end
            end
            if (delay_next > DELAY_W'(1)) begin
                delay_next = delay_next - DELAY_W'(1);
            end else begin
                phase_inc = {1'b0, phase_next} + (PHASE_W+1)'(1);
                if (info.has_loop && phase_next == info.loop_last) begin
                    if (cmd_next == CMD_WRITE) begin
                        shift_next = {shift_next[BYTE_BITS-2:0], 1'b0};
                    end
                    bitcnt_next = bitcnt_next + BITCNT_W'(1);
                    if (bitcnt_next < BITCNT_W'(BYTE_BITS)) begin
                        phase_cand = {1'b0, info.loop_first};
                    end else begin
                        phase_cand = phase_inc;
                    end
                end else begin
                    phase_cand = phase_inc;
                end
                if (phase_cand >= {1'b0, info.count}) begin
                    if (cmd_next == CMD_START) begin
                        clk_lvl_next = 1'b0;
                    end
                    out_done_next = 1'b1;
                    if (cmd_next == CMD_READ_BYTE) begin
                        out_rd_next = shift_next;
                    end
                    cmd_next   = CMD_NONE;
                    phase_next = '0;
                    delay_next = '0;
                end else begin
                    phase_next = phase_cand[PHASE_W-1:0];
                    enter_phase(cmd_next, phase_next, shift_next, ack_send_next, unit,
                                clk_lvl_next, dat_lvl_next, delay_next);
                end
            end
        end

        out_busy_next = (cmd_next != CMD_NONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg       <= CMD_NONE;
            phase_reg     <= '0;
            delay_reg     <= '0;
            bitcnt_reg    <= '0;
            shift_reg     <= '0;
            clk_lvl_reg   <= 1'b1;
            dat_lvl_reg   <= 1'b1;
            ack_seen_reg  <= 1'b0;
            ack_send_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                cmd_reg      <= cmd_next;
                phase_reg    <= phase_next;
                delay_reg    <= delay_next;
                bitcnt_reg   <= bitcnt_next;
                shift_reg    <= shift_next;
                clk_lvl_reg  <= clk_lvl_next;
                dat_lvl_reg  <= dat_lvl_next;
                ack_seen_reg <= ack_seen_next;
                ack_send_reg <= ack_send_next;
            end
            if (q_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_scl_reg  <= out_scl_next;
            out_sda_reg  <= out_sda_next;
            out_busy_reg <= out_busy_next;
            out_done_reg <= out_done_next;
            out_rd_reg   <= out_rd_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_scl_out   = out_scl_reg;
    assign m_sda_out   = out_sda_reg;
    assign m_busy_res  = out_busy_reg;
    assign m_done_res  = out_done_reg;
    assign m_read_data = out_rd_reg;
    assign m_ack_level = ack_seen_reg;

endmodule

`default_nettype wire

// ===== sv/i2c_bitbang_master.sv =====
// Bit-banged I2C master sequencer, top level.
// Depends on i2cbbm_pkg, i2cbbm_front, i2cbbm_queue and i2cbbm_back.
//
// Each request on the s_ channel is one tick of bus time: it carries the
// sampled SDA level and, while the sequencer is idle, a command (start,
// stop, write byte, read ack, read byte, send ack). Every request yields
// exactly one result on the m_ channel with the SCL and SDA drive levels
// for that tick, busy and done flags, the byte read (only on the done tick
// of a read byte command, zero otherwise) and the last slave ack level.
// Commands that arrive while a sequence is running are ignored. Each bus
// phase lasts 1, 2 or 4 delay units of unit_ticks ticks; unit_ticks is set
// through the cfg_ write channel (reset value 100, zero acts as one) and
// should only be written while no request is outstanding. The block takes
// one request per clock cycle while the queue has room: the front end
// classifies requests into a four-entry queue, and the back end sequencer
// retires one queued request per cycle into an output register unless that
// holds a stalled result, so the m_ side may stall while up to four further
// requests are accepted; each passes through the queue, then that register.
`default_nettype none

module i2c_bitbang_master
    import i2cbbm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write channel for unit_ticks.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [UNIT_W-1:0]    cfg_data,
    // Tick request channel.
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [2:0]           s_mode,
    input  wire logic [BYTE_BITS-1:0] s_data_in,
    input  wire logic                 s_ack_in,
    input  wire logic                 s_sda_in,
    // Result channel.
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_scl_out,
    output logic                      m_sda_out,
    output logic                      m_busy_res,
    output logic                      m_done_res,
    output logic [BYTE_BITS-1:0]      m_read_data,
    output logic                      m_ack_level
);

    logic [UNIT_W-1:0] unit_ticks_reg;
    item_t             front_item;
    item_t             head_item;
    logic              q_not_full;
    logic              q_not_empty;
    logic              q_pop;

    // The register is always writable; the user must write it only when idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg <= UNIT_TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unit_ticks_reg <= cfg_data;
        end
    end

    // Front end: decode the mode field into a command record.
    i2cbbm_front u_front (
        .mode    (s_mode),
        .data_in (s_data_in),
        .ack_in  (s_ack_in),
        .sda_in  (s_sda_in),
        .item    (front_item)
    );

    assign s_ready = q_not_full;

    // Decoupling queue: lets the result side stall without stopping intake until the queue is full.
    i2cbbm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // Back end: the phase sequencer and the result register.
    i2cbbm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .unit_ticks  (unit_ticks_reg),
        .q_valid     (q_not_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_out   (m_scl_out),
        .m_sda_out   (m_sda_out),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_read_data (m_read_data),
        .m_ack_level (m_ack_level)
    );

endmodule

`default_nettype wire

// ===== sv/i2cbbm_checker.sv =====
// Port-level checker for the I2C master, bound to the top level.
// Depends on i2cbbm_pkg and on the ports of i2c_bitbang_master.
`default_nettype none

module i2cbbm_checker
    import i2cbbm_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic                 m_scl_out,
    input wire logic                 m_sda_out,
    input wire logic                 m_busy_res,
    input wire logic                 m_done_res,
    input wire logic [BYTE_BITS-1:0] m_read_data,
    input wire logic                 m_ack_level
);

    // A finished command leaves the sequencer idle.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("done result still reports busy");

    // Read data is only shown on a done result.
    a_rdata_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_read_data != '0) |-> m_done_res)
        else $error("read data outside a done result");

    // A read byte command runs for many ticks, so the result delivered right
    // after a read byte completion is never another read byte completion.
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_done_res) |=> !(m_valid && m_done_res && !m_busy_res
            && m_read_data != '0 && $past(m_read_data) != '0))
        else $error("two read byte completions in adjacent results");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_scl_out) && $stable(m_sda_out)
            && $stable(m_busy_res) && $stable(m_done_res) && $stable(m_read_data)
            && $stable(m_ack_level)))
        else $error("stalled result changed");

endmodule

bind i2c_bitbang_master i2cbbm_checker u_i2cbbm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_scl_out   (m_scl_out),
    .m_sda_out   (m_sda_out),
    .m_busy_res  (m_busy_res),
    .m_done_res  (m_done_res),
    .m_read_data (m_read_data),
    .m_ack_level (m_ack_level)
);

`default_nettype wire
